// ----- sv/mbe_pkg.sv -----
`default_nettype none

package mbe_pkg;

    localparam int COORD_W   = 32;
    localparam int WIDE_W    = 64;
    localparam int FRAC_BITS = 28;
    localparam int COUNT_W   = 24;
    localparam int GLYPH_W   = 3;

    localparam int ESCAPE_RADIUS = 2;

    localparam logic [COUNT_W-1:0] MAX_RESET = 24'd1000000;

    // Escape when floor((x*x + y*y) / 2^F) >= 4 * 2^F
    localparam logic [WIDE_W-1:0] ESC_LIMIT =
        WIDE_W'(ESCAPE_RADIUS * ESCAPE_RADIUS) << FRAC_BITS;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -64'sd2147483648;

    localparam logic [GLYPH_W-1:0] GLYPH_DOT   = 3'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_PCT   = 3'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_AT    = 3'd2;
    localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 3'd3;
    localparam logic [GLYPH_W-1:0] GLYPH_HASH  = 3'd4;

    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic mark_escape;
        logic emit;
    } mbe_cmd_t;

    typedef struct packed {
        logic at_limit;
        logic escape_hit;
        logic out_free;
    } mbe_status_t;

    // Clamp a wide signed value to the coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [COORD_W-1:0] r;
        if (v > WIDE_MAX)
        begin
            r = WIDE_MAX[COORD_W-1:0];
        end
        else if (v < WIDE_MIN)
        begin
            r = WIDE_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/mbe_point_if.sv -----
`default_nettype none

interface mbe_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mbe_pkg::COORD_W-1:0]   c_re;
    logic signed [mbe_pkg::COORD_W-1:0]   c_im;

    modport source (output valid, output c_re, output c_im, input ready);
    modport sink   (input valid, input c_re, input c_im, output ready);
endinterface

`default_nettype wire

// ----- sv/mbe_result_if.sv -----
`default_nettype none

interface mbe_result_if;
    logic                          valid;
    logic                          ready;
    logic [mbe_pkg::COUNT_W-1:0]   iteration_count;
    logic                          escaped;
    logic [mbe_pkg::GLYPH_W-1:0]   glyph_class;

    modport source (output valid, output iteration_count, output escaped,
                    output glyph_class, input ready);
    modport sink   (input valid, input iteration_count, input escaped,
                    input glyph_class, output ready);
endinterface

`default_nettype wire

// ----- sv/mbe_cfg_if.sv -----
`default_nettype none

interface mbe_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mbe_pkg::COUNT_W-1:0]   max_iterations;

    modport source (output valid, output max_iterations, input ready);
    modport sink   (input valid, input max_iterations, output ready);
endinterface

`default_nettype wire

// ----- sv/mandelbrot_escape_time.sv -----
`default_nettype none

// Channel  | Dir | Payload                                       | Handshake
// ---------+-----+-----------------------------------------------+-------------
// point    | in  | c_re, c_im (signed Q4.28)                     | valid/ready
// result   | out | iteration_count, escaped, glyph_class         | valid/ready
// cfg      | in  | max_iterations (24 bit)                       | valid/ready
//
// Iteration: each iteration registers the three 32x32 products in S_MUL,
//   then does the escape test and the saturated update of z in S_TEST.
// Reset: rst_n clears the sequencer and the output valid; max_iterations
//   returns to 1000000.
// Stalls: the finished item sits in the output register; the next point is
//   taken while it waits, and the loop holds in its final state only if a
//   second result is ready before the first one is taken.
module mandelbrot_escape_time #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    mbe_point_if.sink       point,
    mbe_result_if.source    result,
    mbe_cfg_if.sink         cfg
);

    // Counter and limit width: the configured limit is masked to both the
    // register width and COUNT_BITS.
    localparam int CNT_W = (COUNT_BITS < mbe_pkg::COUNT_W) ? COUNT_BITS : mbe_pkg::COUNT_W;

    mbe_pkg::mbe_cmd_t    cmd;
    mbe_pkg::mbe_status_t status;
    logic                 in_ready;

    assign point.ready = in_ready;

    // Sequencer: accept, alternate multiply / test-and-update, hand off
    mbe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // z registers, product bank, counter, limit register and output register
    mbe_datapath #(
        .CNT_W (CNT_W)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .c_re   (point.c_re),
        .c_im   (point.c_im),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .status (status)
    );

endmodule

`default_nettype wire

// ----- sv/mbe_ctrl.sv -----
`default_nettype none

module mbe_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire mbe_pkg::mbe_status_t status,
    output mbe_pkg::mbe_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MUL    = 4'b0010,
        S_TEST   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // limit check comes before the magnitude test
                if (status.at_limit)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (status.escape_hit)
                begin
                    cmd.mark_escape = 1'b1;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_load_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_MUL)
        else $error("load did not start the iteration loop");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> state_reg == S_IDLE)
        else $error("emit did not return to idle");

    a_test_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TEST |-> $past(cmd.mul))
        else $error("magnitude test without fresh products");

endmodule

`default_nettype wire

// ----- sv/mbe_datapath.sv -----
`default_nettype none

module mbe_datapath #(
    parameter int CNT_W = 24
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic signed [mbe_pkg::COORD_W-1:0]     c_re,
    input  wire logic signed [mbe_pkg::COORD_W-1:0]     c_im,
    mbe_result_if.source                                result,
    mbe_cfg_if.sink                                     cfg,
    input  wire mbe_pkg::mbe_cmd_t                      cmd,
    output mbe_pkg::mbe_status_t                        status
);

    logic [CNT_W-1:0]                       max_reg;
    logic [CNT_W-1:0]                       iter_reg;
    logic                                   esc_reg;
    logic signed [mbe_pkg::COORD_W-1:0]     x_reg;
    logic signed [mbe_pkg::COORD_W-1:0]     y_reg;
    logic signed [mbe_pkg::COORD_W-1:0]     c_re_reg;
    logic signed [mbe_pkg::COORD_W-1:0]     c_im_reg;
    logic signed [mbe_pkg::WIDE_W-1:0]      xx_reg;
    logic signed [mbe_pkg::WIDE_W-1:0]      yy_reg;
    logic signed [mbe_pkg::WIDE_W-1:0]      xy_reg;

    logic                                   out_valid_reg;
    logic [mbe_pkg::COUNT_W-1:0]            out_count_reg;
    logic                                   out_esc_reg;
    logic [mbe_pkg::GLYPH_W-1:0]            out_glyph_reg;

    logic [mbe_pkg::WIDE_W-1:0]             sum_sq;
    logic signed [mbe_pkg::WIDE_W-1:0]      diff_sq;
    logic signed [mbe_pkg::WIDE_W-1:0]      c_re_ext;
    logic signed [mbe_pkg::WIDE_W-1:0]      c_im_ext;
    logic signed [mbe_pkg::WIDE_W-1:0]      x_wide;
    logic signed [mbe_pkg::WIDE_W-1:0]      y_wide;
    logic [mbe_pkg::GLYPH_W-1:0]            glyph;

    assign cfg.ready = 1'b1;

    // Escape test and next z from the registered products
    assign sum_sq   = unsigned'(xx_reg) + unsigned'(yy_reg);
    assign diff_sq  = xx_reg - yy_reg;
    assign c_re_ext = {{(mbe_pkg::WIDE_W-mbe_pkg::COORD_W){c_re_reg[mbe_pkg::COORD_W-1]}},
                       c_re_reg};
    assign c_im_ext = {{(mbe_pkg::WIDE_W-mbe_pkg::COORD_W){c_im_reg[mbe_pkg::COORD_W-1]}},
                       c_im_reg};
    assign x_wide   = (diff_sq >>> mbe_pkg::FRAC_BITS) + c_re_ext;
    assign y_wide   = (xy_reg >>> (mbe_pkg::FRAC_BITS - 1)) + c_im_ext;

    assign status.at_limit   = (iter_reg == max_reg);
    assign status.escape_hit = ((sum_sq >> mbe_pkg::FRAC_BITS) >= mbe_pkg::ESC_LIMIT);
    assign status.out_free   = !out_valid_reg || result.ready;

    // Small counts first, then the limit
    always_comb
    begin
        if (iter_reg == '0)
        begin
            glyph = mbe_pkg::GLYPH_DOT;
        end
        else if (iter_reg == CNT_W'(1))
        begin
            glyph = mbe_pkg::GLYPH_PCT;
        end
        else if (iter_reg == CNT_W'(2))
        begin
            glyph = mbe_pkg::GLYPH_AT;
        end
        else if (iter_reg == max_reg)
        begin
            glyph = mbe_pkg::GLYPH_SPACE;
        end
        else
        begin
            glyph = mbe_pkg::GLYPH_HASH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= CNT_W'(mbe_pkg::MAX_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                max_reg <= cfg.max_iterations[CNT_W-1:0];
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c_re_reg <= c_re;
            c_im_reg <= c_im;
            x_reg    <= '0;
            y_reg    <= '0;
            iter_reg <= '0;
            esc_reg  <= 1'b0;
        end
        if (cmd.mul)
        begin
            xx_reg <= x_reg * x_reg;
            yy_reg <= y_reg * y_reg;
            xy_reg <= x_reg * y_reg;
        end
        if (cmd.step)
        begin
            x_reg    <= mbe_pkg::sat_coord(x_wide);
            y_reg    <= mbe_pkg::sat_coord(y_wide);
            iter_reg <= iter_reg + CNT_W'(1);
        end
        if (cmd.mark_escape)
        begin
            esc_reg <= 1'b1;
        end
        if (cmd.emit)
        begin
            out_count_reg <= mbe_pkg::COUNT_W'(iter_reg);
            out_esc_reg   <= esc_reg;
            out_glyph_reg <= glyph;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.iteration_count = out_count_reg;
    assign result.escaped         = out_esc_reg;
    assign result.glyph_class     = out_glyph_reg;

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result overwritten before it was taken");

    a_load_clears_z: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (x_reg == '0) && (y_reg == '0) && (iter_reg == '0) && !esc_reg)
        else $error("iteration state not cleared on load");

    a_step_counts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |=> iter_reg == $past(iter_reg) + CNT_W'(1))
        else $error("iteration counter did not advance");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;

    localparam int          WATCHDOG_LIMIT    = 20000;
    localparam int          SETTLE_CYCLES     = 6;
    localparam int          TAIL_CYCLES       = 20;
    localparam int          RANDOM_PHASES     = 5;
    localparam int          POINTS_PER_PHASE  = 15;
    localparam int          DIRECTED_ROWS     = 24;

    localparam logic [mbe_pkg::COUNT_W-1:0] LIMIT_AFTER_RESET = 24'd1000000;
    localparam logic [mbe_pkg::COUNT_W-1:0] LIMIT_TOP         = 24'hFFFFFF;

    // Escape threshold: floor((x*x + y*y) / 2^F) >= 4 * 2^F
    localparam logic [mbe_pkg::WIDE_W-1:0] FOUR_SCALED = 64'd4 << mbe_pkg::FRAC_BITS;
    localparam longint COORD_TOP    = 64'sd2147483647;
    localparam longint COORD_BOTTOM = -64'sd2147483648;

    // Handy Q4.28 points
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_MAX      = 32'sh7FFFFFFF;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_MIN      = 32'sh80000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_ZERO     = 32'sh00000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_TWO      = 32'sh20000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_NEG_TWO  = 32'shE0000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_NEAR_TWO = 32'sh1FFFFFFF;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_ONE_HALF = 32'sh18000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_ONE      = 32'sh10000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_NEG_ONE  = 32'shF0000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_HALF     = 32'sh08000000;
    localparam logic signed [mbe_pkg::COORD_W-1:0] C_QUARTER  = 32'sh04000000;

    // One prediction: what the block should report for one point
    typedef struct packed {
        logic [mbe_pkg::COUNT_W-1:0] count;
        logic                        escaped;
        logic [mbe_pkg::GLYPH_W-1:0] glyph;
    } escape_rec_t;

    // One directed row: optional limit write, the point, and, where it is
    // obvious, the expected answer typed in
    typedef struct packed {
        logic                                 set_lim;
        logic [mbe_pkg::COUNT_W-1:0]          lim;
        logic signed [mbe_pkg::COORD_W-1:0]   re;
        logic signed [mbe_pkg::COORD_W-1:0]   im;
        logic                                 known;
        logic [mbe_pkg::COUNT_W-1:0]          cnt;
        logic                                 esc;
        logic [mbe_pkg::GLYPH_W-1:0]          gly;
    } point_row_t;

    localparam point_row_t DIR_ROWS [DIRECTED_ROWS] = '{
        // reset limit: far points escape right after the first iteration
        '{1'b0, 24'd0, C_MAX, C_MAX, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_MIN, C_MIN, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        // |z| exactly 2 must count as escaped
        '{1'b0, 24'd0, C_TWO, C_ZERO, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_NEG_TWO, C_ZERO, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_NEAR_TWO, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        // zero limit: no iteration at all
        '{1'b1, 24'd0, C_ZERO, C_ZERO, 1'b1, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b0, 24'd0, C_MAX, C_MIN, 1'b1, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        // limits of one, two and three: for one and two the count tests win over the limit test
        '{1'b1, 24'd1, C_ZERO, C_ZERO, 1'b1, 24'd1, 1'b0, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_MAX, C_ZERO, 1'b1, 24'd1, 1'b0, mbe_pkg::GLYPH_PCT},
        '{1'b1, 24'd2, C_ZERO, C_ZERO, 1'b1, 24'd2, 1'b0, mbe_pkg::GLYPH_AT},
        '{1'b0, 24'd0, C_MIN, C_ZERO, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_ONE_HALF, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b1, 24'd3, C_ZERO, C_ZERO, 1'b1, 24'd3, 1'b0, mbe_pkg::GLYPH_SPACE},
        '{1'b0, 24'd0, C_ONE_HALF, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        // top limit: only points that leave fast
        '{1'b1, LIMIT_TOP, C_MAX, C_ZERO, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_TWO, C_MIN, 1'b1, 24'd1, 1'b1, mbe_pkg::GLYPH_PCT},
        '{1'b0, 24'd0, C_NEAR_TWO, 32'sh00000001, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        // moderate limit: inside points, slow escapes, the generic glyph
        '{1'b1, 24'd40, C_ZERO, C_ZERO, 1'b1, 24'd40, 1'b0, mbe_pkg::GLYPH_SPACE},
        '{1'b0, 24'd0, C_HALF, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b0, 24'd0, C_NEG_ONE, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b0, 24'd0, C_ZERO, C_ONE, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b0, 24'd0, C_QUARTER, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b0, 24'd0, 32'sh04200000, C_ZERO, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT},
        '{1'b0, 24'd0, 32'shF4000000, 32'sh01999999, 1'b0, 24'd0, 1'b0, mbe_pkg::GLYPH_DOT}
    };

    logic clk = 1'b0;
    logic rst_n;

    mbe_point_if  point_ch ();
    mbe_result_if result_ch ();
    mbe_cfg_if    cfg_ch ();

    mandelbrot_escape_time dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .point  (point_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Expected answers, oldest first, pushed when a point is accepted
    escape_rec_t                 pending_escapes[$];
    logic [mbe_pkg::COUNT_W-1:0] iter_limit = LIMIT_AFTER_RESET;
    logic                        calm = 1'b0;
    int                          points_sent = 0;
    int                          results_checked = 0;
    int                          limits_written = 0;
    int                          mismatches = 0;
    int                          quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Saturate to the signed 32-bit coordinate range
    function automatic longint clamp_coord(input longint v);
        if (v > COORD_TOP)
        begin
            return COORD_TOP;
        end
        if (v < COORD_BOTTOM)
        begin
            return COORD_BOTTOM;
        end
        return v;
    endfunction

    // Iterate z = z*z + c from z = 0 until |z| >= 2 or the limit runs out
    function automatic escape_rec_t predict_escape(
        input logic signed [mbe_pkg::COORD_W-1:0] cre,
        input logic signed [mbe_pkg::COORD_W-1:0] cim,
        input logic [mbe_pkg::COUNT_W-1:0]        lim
    );
        longint       x;
        longint       y;
        longint       xx;
        longint       yy;
        longint       nx;
        longint       ny;
        logic [63:0]  sq_sum;
        int unsigned  k;
        escape_rec_t  r;
        x = 0;
        y = 0;
        r.count = lim;
        r.escaped = 1'b0;
        for (k = 0; k < lim; k++)
        begin
            xx = x * x;
            yy = y * y;
            // the sum may reach 2^63; treat it as unsigned
            sq_sum = xx + yy;
            if ((sq_sum >> mbe_pkg::FRAC_BITS) >= FOUR_SCALED)
            begin
                r.count = k;
                r.escaped = 1'b1;
                break;
            end
            nx = clamp_coord(((xx - yy) >>> mbe_pkg::FRAC_BITS) + longint'(cre));
            ny = clamp_coord(((x * y) >>> (mbe_pkg::FRAC_BITS - 1)) + longint'(cim));
            x = nx;
            y = ny;
        end
        if (r.count == 0)
        begin
            r.glyph = mbe_pkg::GLYPH_DOT;
        end
        else if (r.count == 1)
        begin
            r.glyph = mbe_pkg::GLYPH_PCT;
        end
        else if (r.count == 2)
        begin
            r.glyph = mbe_pkg::GLYPH_AT;
        end
        else if (r.count == lim)
        begin
            r.glyph = mbe_pkg::GLYPH_SPACE;
        end
        else
        begin
            r.glyph = mbe_pkg::GLYPH_HASH;
        end
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long; none in a calm phase
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
        begin
            return 0;
        end
        r = $urandom_range(99, 0);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(3, 1);
        end
        if (r < 97)
        begin
            return $urandom_range(10, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH result %0d %s: got %0d, want %0d", results_checked, what, got, want);
        mismatches++;
    endtask

    // Present one point after a random gap; record its answer on acceptance.
    // Valid stays high from the last item when there is no gap, so it is
    // never dropped and raised in the same step.
    task automatic send_point(
        input logic signed [mbe_pkg::COORD_W-1:0] re,
        input logic signed [mbe_pkg::COORD_W-1:0] im,
        input escape_rec_t                        want
    );
        int unsigned gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            point_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.c_re  <= re;
        point_ch.c_im  <= im;
        do @(posedge clk); while (point_ch.ready !== 1'b1);
        pending_escapes.push_back(want);
        points_sent++;
    endtask

    // Drain the block, let it settle for SETTLE_CYCLES to go idle, then write the limit
    task automatic write_limit(input logic [mbe_pkg::COUNT_W-1:0] v);
        @(negedge clk);
        point_ch.valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.max_iterations <= v;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        iter_limit = v;
        limits_written++;
    endtask

    // Stimulus: reset, directed table, then random phases at varied limits
    initial
    begin
        escape_rec_t                        want;
        logic signed [mbe_pkg::COORD_W-1:0] re;
        logic signed [mbe_pkg::COORD_W-1:0] im;
        logic signed [mbe_pkg::COORD_W-1:0] mag;
        logic [mbe_pkg::COUNT_W-1:0]        phase_limits [RANDOM_PHASES];
        int unsigned                        pick;

        rst_n                 = 1'b0;
        point_ch.valid        = 1'b0;
        point_ch.c_re         = '0;
        point_ch.c_im         = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.max_iterations = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the table; typed answers are used as they stand
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (DIR_ROWS[i].set_lim)
            begin
                write_limit(DIR_ROWS[i].lim);
            end
            if (DIR_ROWS[i].known)
            begin
                want.count   = DIR_ROWS[i].cnt;
                want.escaped = DIR_ROWS[i].esc;
                want.glyph   = DIR_ROWS[i].gly;
            end
            else
            begin
                want = predict_escape(DIR_ROWS[i].re, DIR_ROWS[i].im, iter_limit);
            end
            send_point(DIR_ROWS[i].re, DIR_ROWS[i].im, want);
        end

        // Tiny, small, moderate, top and medium limits; the top one only
        // gets points that leave at once so the run stays short
        phase_limits[0] = mbe_pkg::COUNT_W'($urandom_range(3, 1));
        phase_limits[1] = mbe_pkg::COUNT_W'($urandom_range(64, 4));
        phase_limits[2] = 24'd1000;
        phase_limits[3] = LIMIT_TOP;
        phase_limits[4] = mbe_pkg::COUNT_W'($urandom_range(400, 65));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_limit(phase_limits[ph]);
            calm = ($urandom_range(3, 0) == 0);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                pick = $urandom_range(99, 0);
                if (phase_limits[ph] == LIMIT_TOP)
                begin
                    // |c_re| >= 2 escapes after the first iteration
                    mag = $urandom_range(32'h7FFFFFFF, 32'h20000000);
                    re  = $urandom_range(1, 0) ? -mag : mag;
                    im  = $urandom;
                end
                else if (pick < 70)
                begin
                    // the region around the set, where counts vary most
                    re = $urandom_range(32'h30000000, 0) - 32'sh24000000;
                    im = $urandom_range(32'h30000000, 0) - 32'sh18000000;
                end
                else if (pick < 85)
                begin
                    re = $urandom;
                    im = $urandom;
                end
                else
                begin
                    re = $urandom_range(32'h10000000, 0) - 32'sh08000000;
                    im = $urandom_range(32'h10000000, 0) - 32'sh08000000;
                end
                want = predict_escape(re, im, iter_limit);
                send_point(re, im, want);
            end
        end
        calm = 1'b0;

        @(negedge clk);
        point_ch.valid <= 1'b0;
        while (pending_escapes.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d points over %0d limit settings, %0d results compared",
                 points_sent, limits_written + 1, results_checked);
        $display("directed: field extremes, |z| = 2 edge, limits 0 to 3 and 2^24-1; "
                 , "random: five limit phases with stalls");
        if (mismatches == 0)
        begin
            $display("mandelbrot_escape_time test passed");
        end
        else
        begin
            $display("mandelbrot_escape_time test failed");
        end
        $finish;
    end

    // Result side: stall at random, then take one item and check it
    initial
    begin
        escape_rec_t want;
        int unsigned gap;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap();
            @(negedge clk);
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (result_ch.valid !== 1'b1);
            if (pending_escapes.size() == 0)
            begin
                report_mismatch("arrived with nothing pending",
                                result_ch.iteration_count, 0);
            end
            else
            begin
                want = pending_escapes.pop_front();
                if (result_ch.iteration_count !== want.count)
                begin
                    report_mismatch("iteration_count", result_ch.iteration_count, want.count);
                end
                if (result_ch.escaped !== want.escaped)
                begin
                    report_mismatch("escaped", result_ch.escaped, want.escaped);
                end
                if (result_ch.glyph_class !== want.glyph)
                begin
                    report_mismatch("glyph_class", result_ch.glyph_class, want.glyph);
                end
            end
            results_checked++;
        end
    end

    // Watchdog: end the run if no channel moves an item for too long
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            quiet_cycles = 0;
        end
        else if ((point_ch.valid && point_ch.ready) ||
                 (result_ch.valid && result_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles, %0d results pending",
                         quiet_cycles, pending_escapes.size());
                $display("mandelbrot_escape_time test failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/mbe_pkg.sv
sv/mbe_point_if.sv
sv/mbe_result_if.sv
sv/mbe_cfg_if.sv
sv/mbe_ctrl.sv
sv/mbe_datapath.sv
sv/mandelbrot_escape_time.sv
tb/testbench.sv
